/* hw/rtl/hsv_to_rgbw_converter_top_defines.svh */
// Assertion macros shared by the HSV to RGBW converter RTL.
// Needs a clock named aclk and an active-low reset named aresetn in the using scope.
`ifndef HSV_TO_RGBW_CONVERTER_TOP_DEFINES_SVH
`define HSV_TO_RGBW_CONVERTER_TOP_DEFINES_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define HSVRGB_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("hsvrgb same-cycle check failed");

// Next-cycle implication, checked on every clock edge outside reset.
`define HSVRGB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("hsvrgb next-cycle check failed");

`endif

/* hw/rtl/hsvrgb_pkg.sv */
// Package for the HSV to RGBW converter: fixed constants and shared types.
// Used by hsvrgb_chan and hsv_to_rgbw_converter_top; depends on nothing.
`default_nettype none

package hsvrgb_pkg;

    // Input field widths and valid limits.
    localparam int unsigned HUE_W   = 9;
    localparam int unsigned PCT_W   = 7;
    localparam int unsigned LEVEL_W = 8;

    localparam logic [HUE_W-1:0] HUE_MAX = 9'd360;
    localparam logic [PCT_W-1:0] PCT_MAX = 7'd100;

    // Hue arithmetic in whole degrees.
    localparam logic [9:0] HUE_FULL     = 10'd360;
    localparam logic [8:0] HUE_RISE_END = 9'd120;
    localparam logic [8:0] HUE_FALL_END = 9'd240;
    localparam logic [7:0] SECTOR_DEG   = 8'd60;

    // Per-channel hue offsets, 60 degrees times n (n = 5, 3, 1).
    localparam logic [HUE_W-1:0] RED_OFFSET   = 9'd300;
    localparam logic [HUE_W-1:0] GREEN_OFFSET = 9'd180;
    localparam logic [HUE_W-1:0] BLUE_OFFSET  = 9'd60;

    // Full-scale product of saturation percent and the 60-degree ramp.
    localparam logic [12:0] SAT_FULL = 13'd6000;

    // Reciprocal of 625 scaled by 2^28, rounded up; exact for quotients below 2^18.
    localparam logic [18:0] RECIP_625   = 19'd429497;
    localparam int unsigned RECIP_SHIFT = 28;

    // Per-stage load enables of the datapath pipeline.
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
        logic s5;
    } stage_en_t;

endpackage

`default_nettype wire

/* hw/rtl/hsvrgb_chan.sv */
// One color channel of the HSV to RGBW converter: a five-stage pipeline from hue to level.
// Depends on hsvrgb_pkg; the shared saturation and value stages come from the top level.
`default_nettype none

module hsvrgb_chan (
    input  wire logic                                  aclk,
    input  wire hsvrgb_pkg::stage_en_t                 stage_en,
    input  wire logic [hsvrgb_pkg::HUE_W-1:0]          hue,
    input  wire logic [hsvrgb_pkg::HUE_W-1:0]          hue_offset,
    input  wire logic [hsvrgb_pkg::PCT_W-1:0]          sat_s1,
    input  wire logic [hsvrgb_pkg::PCT_W-1:0]          val_s2,
    output logic      [hsvrgb_pkg::LEVEL_W-1:0]        level
);

    // Stage 1: shifted hue modulo 360 and the clamped 0..60 ramp.
    logic [9:0]  hue_sum;
    logic [8:0]  hue_mod;
    logic [8:0]  ramp_raw;
    logic [5:0]  ramp_next;
    logic [5:0]  ramp_reg;

    always_comb begin
        hue_sum = {1'b0, hue} + {1'b0, hue_offset};
        if (hue_sum >= hsvrgb_pkg::HUE_FULL) begin
            hue_mod = 9'(hue_sum - hsvrgb_pkg::HUE_FULL);
        end else begin
            hue_mod = hue_sum[8:0];
        end
        if (hue_mod < hsvrgb_pkg::HUE_RISE_END) begin
            ramp_raw = hue_mod;
        end else if (hue_mod < hsvrgb_pkg::HUE_FALL_END) begin
            ramp_raw = hsvrgb_pkg::HUE_FALL_END - hue_mod;
        end else begin
            ramp_raw = '0;
        end
        if (ramp_raw > {1'b0, hsvrgb_pkg::SECTOR_DEG}) begin
            ramp_next = hsvrgb_pkg::SECTOR_DEG[5:0];
        end else begin
            ramp_next = ramp_raw[5:0];
        end
    end

    // Stage 2: the saturation term, 6000 - s * m.
    logic [12:0] sat_term;
    logic [12:0] fade_next;
    logic [12:0] fade_reg;

    always_comb begin
        sat_term  = 13'(sat_s1) * 13'(ramp_reg);
        fade_next = hsvrgb_pkg::SAT_FULL - sat_term;
    end

    // Stage 3: scale by value, v * (6000 - s * m).
    logic [19:0] prod_next;
    logic [19:0] prod_reg;

    assign prod_next = 20'(val_s2) * 20'(fade_reg);

    // Stage 4: times 17, then drop six bits; 255 / 600000 equals 17 / (64 * 625).
    logic [24:0] times17;
    logic [17:0] quot_next;
    logic [17:0] quot_reg;

    always_comb begin
        times17   = {prod_reg, 4'b0000} + 25'(prod_reg);
        quot_next = times17[23:6];
    end

    // Stage 5: divide by 625 through the scaled reciprocal.
    logic [36:0] recip_prod;
    logic [hsvrgb_pkg::LEVEL_W-1:0] level_next;
    logic [hsvrgb_pkg::LEVEL_W-1:0] level_reg;

    always_comb begin
        recip_prod = 37'(quot_reg) * 37'(hsvrgb_pkg::RECIP_625);
        level_next = recip_prod[hsvrgb_pkg::RECIP_SHIFT +: hsvrgb_pkg::LEVEL_W];
    end

    // Payload registers, each loaded when its stage advances.
    always_ff @(posedge aclk) begin
        if (stage_en.s1) begin
            ramp_reg <= ramp_next;
        end
        if (stage_en.s2) begin
            fade_reg <= fade_next;
        end
        if (stage_en.s3) begin
            prod_reg <= prod_next;
        end
        if (stage_en.s4) begin
            quot_reg <= quot_next;
        end
        if (stage_en.s5) begin
            level_reg <= level_next;
        end
    end

    assign level = level_reg;

endmodule

`default_nettype wire

/* hw/rtl/hsv_to_rgbw_converter_top.sv */
// Top level of the HSV to RGBW converter: stream ports, range check and pipeline control.
// Depends on hsvrgb_pkg, hsvrgb_chan and hsv_to_rgbw_converter_top_defines.svh.
//
// Usage:
// The slave channel takes one color per transaction: hue in degrees (0..360),
// saturation and value in percent (0..100). The master channel returns one
// transaction per input with 8-bit red, green and blue, white fixed at zero,
// and tuser set when any input was out of range (then all levels are zero).
// Each accepted input passes through the five register stages to the master
// side. The pipeline takes one transaction every cycle while it has room;
// that rate is set by the five register stages, each loaded whenever the
// stage after it has room. A stalled receiver holds the result in place;
// bubbles are filled first; s_tready drops only once all five stages hold data.
// Reset clears all valid bits; the datapath registers are not reset.
`default_nettype none

module hsv_to_rgbw_converter_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // [8:0] hue, [15:9] saturation,
                                        // [22:16] brightness_value, [23] zero fill
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [31:0] m_tdata,   // [7:0] red, [15:8] green, [23:16] blue,
                                        // [31:24] white
    output logic             m_tuser    // [0] out_of_range
);

    `include "hsv_to_rgbw_converter_top_defines.svh"

    // Unpack the input transaction.
    logic [hsvrgb_pkg::HUE_W-1:0] hue;
    logic [hsvrgb_pkg::PCT_W-1:0] saturation;
    logic [hsvrgb_pkg::PCT_W-1:0] brightness_value;

    assign hue              = s_tdata[8:0];
    assign saturation       = s_tdata[15:9];
    assign brightness_value = s_tdata[22:16];

    // Stage valid bits and the ready chain from the output back to the input.
    logic vld1_reg, vld2_reg, vld3_reg, vld4_reg, vld5_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy5;
    hsvrgb_pkg::stage_en_t stage_en;

    always_comb begin
        rdy5 = !vld5_reg || m_tready;
        rdy4 = !vld4_reg || rdy5;
        rdy3 = !vld3_reg || rdy4;
        rdy2 = !vld2_reg || rdy3;
        rdy1 = !vld1_reg || rdy2;
        stage_en.s1 = rdy1;
        stage_en.s2 = rdy2;
        stage_en.s3 = rdy3;
        stage_en.s4 = rdy4;
        stage_en.s5 = rdy5;
    end

    assign s_tready = rdy1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
            vld4_reg <= 1'b0;
            vld5_reg <= 1'b0;
        end else begin
            if (rdy1) begin
                vld1_reg <= s_tvalid;
            end
            if (rdy2) begin
                vld2_reg <= vld1_reg;
            end
            if (rdy3) begin
                vld3_reg <= vld2_reg;
            end
            if (rdy4) begin
                vld4_reg <= vld3_reg;
            end
            if (rdy5) begin
                vld5_reg <= vld4_reg;
            end
        end
    end

    // Range check; an out-of-range input runs with zero value so every level ends at zero.
    logic oor_next;
    logic [hsvrgb_pkg::PCT_W-1:0] val_next;

    always_comb begin
        oor_next = (hue > hsvrgb_pkg::HUE_MAX) || (saturation > hsvrgb_pkg::PCT_MAX)
                   || (brightness_value > hsvrgb_pkg::PCT_MAX);
        val_next = oor_next ? '0 : brightness_value;
    end

    // Shared saturation, value and flag registers that travel with the channels.
    logic [hsvrgb_pkg::PCT_W-1:0] sat1_reg;
    logic [hsvrgb_pkg::PCT_W-1:0] val1_reg;
    logic [hsvrgb_pkg::PCT_W-1:0] val2_reg;
    logic oor1_reg, oor2_reg, oor3_reg, oor4_reg, oor5_reg;

    always_ff @(posedge aclk) begin
        if (rdy1) begin
            sat1_reg <= saturation;
            val1_reg <= val_next;
            oor1_reg <= oor_next;
        end
        if (rdy2) begin
            val2_reg <= val1_reg;
            oor2_reg <= oor1_reg;
        end
        if (rdy3) begin
            oor3_reg <= oor2_reg;
        end
        if (rdy4) begin
            oor4_reg <= oor3_reg;
        end
        if (rdy5) begin
            oor5_reg <= oor4_reg;
        end
    end

    // Three channel pipelines, one per primary.
    logic [hsvrgb_pkg::LEVEL_W-1:0] red;
    logic [hsvrgb_pkg::LEVEL_W-1:0] green;
    logic [hsvrgb_pkg::LEVEL_W-1:0] blue;

    hsvrgb_chan u_chan_red (
        .aclk       (aclk),
        .stage_en   (stage_en),
        .hue        (hue),
        .hue_offset (hsvrgb_pkg::RED_OFFSET),
        .sat_s1     (sat1_reg),
        .val_s2     (val2_reg),
        .level      (red)
    );

    hsvrgb_chan u_chan_green (
        .aclk       (aclk),
        .stage_en   (stage_en),
        .hue        (hue),
        .hue_offset (hsvrgb_pkg::GREEN_OFFSET),
        .sat_s1     (sat1_reg),
        .val_s2     (val2_reg),
        .level      (green)
    );

    hsvrgb_chan u_chan_blue (
        .aclk       (aclk),
        .stage_en   (stage_en),
        .hue        (hue),
        .hue_offset (hsvrgb_pkg::BLUE_OFFSET),
        .sat_s1     (sat1_reg),
        .val_s2     (val2_reg),
        .level      (blue)
    );

    // Output transaction; white is always zero.
    assign m_tvalid = vld5_reg;
    assign m_tdata  = {8'h00, blue, green, red};
    assign m_tuser  = oor5_reg;

    // An out-of-range result carries zero levels.
    `HSVRGB_ASSERT_IMPL(a_oor_zero, m_tvalid && m_tuser, m_tdata[23:0] == 24'h000000)
    // With every stage full and the receiver stalled, no new transaction is taken.
    `HSVRGB_ASSERT_IMPL(a_full_backpressure,
        vld1_reg && vld2_reg && vld3_reg && vld4_reg && vld5_reg && !m_tready, !s_tready)
    // A bad hue taken at the input shows up flagged in the first stage.
    `HSVRGB_ASSERT_NEXT(a_hue_flagged,
        s_tvalid && s_tready && (hue > hsvrgb_pkg::HUE_MAX), vld1_reg && oor1_reg)

endmodule

`default_nettype wire

/* tb/sv/tb_hsv_to_rgbw_converter_top.sv */
// Self-checking testbench for hsv_to_rgbw_converter_top: directed and random colors,
// each result compared with an integer HSV-to-RGB predictor held in this file.
// Depends on hsvrgb_pkg and the converter RTL only.
`default_nettype none

module tb_hsv_to_rgbw_converter_top;
    timeunit 1ns;
    timeprecision 1ps;

    // Field widths and limits taken from the package.
    localparam int unsigned LEVEL_W = hsvrgb_pkg::LEVEL_W;
    localparam int unsigned HUE_W   = hsvrgb_pkg::HUE_W;
    localparam int unsigned PCT_W   = hsvrgb_pkg::PCT_W;
    localparam logic [HUE_W-1:0] HUE_MAX = hsvrgb_pkg::HUE_MAX;
    localparam logic [PCT_W-1:0] PCT_MAX = hsvrgb_pkg::PCT_MAX;

    localparam int unsigned RED_SHIFT_DEG   = 300;
    localparam int unsigned GREEN_SHIFT_DEG = 180;
    localparam int unsigned BLUE_SHIFT_DEG  = 60;
    localparam int unsigned IDLE_PCT        = 33;
    localparam int unsigned LONG_HOLD       = 60;
    localparam int unsigned RANDOM_COLORS   = 1000;
    localparam int unsigned DRAIN_CYCLES    = 12;

    // One converted color as it appears on the master side.
    typedef struct packed {
        logic [LEVEL_W-1:0] red;
        logic [LEVEL_W-1:0] green;
        logic [LEVEL_W-1:0] blue;
        logic [LEVEL_W-1:0] white;
        logic               out_of_range;
    } rgbw_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic        m_tuser;

    rgbw_t       expected_colors[$];
    int unsigned error_count;
    bit          steady_mode;     // disables idling on both sides
    int unsigned hold_requests;   // bumped by the stimulus to ask for a long receiver hold

    hsv_to_rgbw_converter_top i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Clock generation.
    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Run limit.
    initial begin
        #5ms;
        $display("tb_hsv_to_rgbw_converter_top failed");
        $finish;
    end

    // Level of one channel: ramp position m in 0..60 from the shifted hue, then scale.
    function automatic logic [LEVEL_W-1:0] channel_level(int unsigned shift_deg,
                                                         logic [HUE_W-1:0] hue,
                                                         logic [PCT_W-1:0] sat,
                                                         logic [PCT_W-1:0] val);
        int k;
        int m;
        int unsigned num;
        k = int'((shift_deg + hue) % 360);
        m = (k < 240 - k) ? k : 240 - k;
        if (m < 0) m = 0;
        if (m > 60) m = 60;
        num = 255 * val * (6000 - sat * m);
        return LEVEL_W'(num / 600000);
    endfunction

    // Expected result for one accepted color.
    function automatic rgbw_t convert_hsv(logic [HUE_W-1:0] hue, logic [PCT_W-1:0] sat,
                                          logic [PCT_W-1:0] val);
        rgbw_t color;
        color = '0;
        if (hue > HUE_MAX || sat > PCT_MAX || val > PCT_MAX) begin
            color.out_of_range = 1'b1;
        end else begin
            color.red   = channel_level(RED_SHIFT_DEG, hue, sat, val);
            color.green = channel_level(GREEN_SHIFT_DEG, hue, sat, val);
            color.blue  = channel_level(BLUE_SHIFT_DEG, hue, sat, val);
        end
        return color;
    endfunction

    // Offer one color and wait for its transaction; the expectation is queued on acceptance.
    // Each cycle before the offer is idle with a fixed chance, so idling stays near one third.
    task automatic send_color(logic [HUE_W-1:0] hue, logic [PCT_W-1:0] sat,
                              logic [PCT_W-1:0] val);
        @(negedge aclk);
        while (!steady_mode && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, val, sat, hue};
        do @(posedge aclk); while (!s_tready);
        expected_colors.push_back(convert_hsv(hue, sat, val));
    endtask

    // Lower valid and wait until every expected result has come back.
    task automatic wait_for_drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_colors.size() != 0) @(posedge aclk);
    endtask

    // Receiver: random stalls, plus a long hold whenever the stimulus asks for one.
    initial begin
        int unsigned hold_left;
        int unsigned holds_served;
        hold_left    = 0;
        holds_served = 0;
        m_tready     = 1'b0;
        forever begin
            @(negedge aclk);
            if (holds_served != hold_requests) begin
                holds_served = hold_requests;
                hold_left    = LONG_HOLD;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (steady_mode) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // Result checker: each transaction against the oldest expectation.
    always @(posedge aclk) begin
        rgbw_t got;
        rgbw_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tdata[7:0], m_tdata[15:8], m_tdata[23:16], m_tdata[31:24], m_tuser};
            if (expected_colors.size() == 0) begin
                $display("%0t: unexpected result transaction, actual %h", $realtime, got);
                error_count++;
            end else begin
                want = expected_colors.pop_front();
                if (got.red !== want.red) begin
                    $display("%0t: red mismatch, expected %0d, actual %0d",
                             $realtime, want.red, got.red);
                    error_count++;
                end
                if (got.green !== want.green) begin
                    $display("%0t: green mismatch, expected %0d, actual %0d",
                             $realtime, want.green, got.green);
                    error_count++;
                end
                if (got.blue !== want.blue) begin
                    $display("%0t: blue mismatch, expected %0d, actual %0d",
                             $realtime, want.blue, got.blue);
                    error_count++;
                end
                if (got.white !== want.white) begin
                    $display("%0t: white mismatch, expected %0d, actual %0d",
                             $realtime, want.white, got.white);
                    error_count++;
                end
                if (got.out_of_range !== want.out_of_range) begin
                    $display("%0t: out_of_range mismatch, expected %0d, actual %0d",
                             $realtime, want.out_of_range, got.out_of_range);
                    error_count++;
                end
            end
        end
    end

    // Field extremes, every hue sector boundary and the out-of-range cases.
    task automatic test_directed_extremes();
        send_color(9'd0, 7'd0, 7'd0);
        send_color(9'd0, 7'd100, 7'd100);
        send_color(9'd60, 7'd100, 7'd100);
        send_color(9'd120, 7'd100, 7'd100);
        send_color(9'd180, 7'd100, 7'd100);
        send_color(9'd240, 7'd100, 7'd100);
        send_color(9'd300, 7'd100, 7'd100);
        send_color(9'd359, 7'd100, 7'd100);
        // A hue of exactly 360 is valid and must match hue 0.
        send_color(9'd360, 7'd100, 7'd100);
        send_color(9'd360, 7'd0, 7'd100);
        // Out of range on each field in turn, then all at once.
        send_color(9'd361, 7'd50, 7'd50);
        send_color(9'd0, 7'd101, 7'd50);
        send_color(9'd0, 7'd50, 7'd101);
        send_color(9'd511, 7'd127, 7'd127);
        send_color(9'd511, 7'd0, 7'd0);
        send_color(9'd0, 7'd127, 7'd0);
        send_color(9'd0, 7'd0, 7'd127);
        // Mid-ramp points where truncation matters.
        send_color(9'd30, 7'd50, 7'd50);
        send_color(9'd90, 7'd75, 7'd33);
        send_color(9'd200, 7'd100, 7'd1);
        send_color(9'd330, 7'd1, 7'd99);
        send_color(9'd255, 7'd85, 7'd42);
        wait_for_drain();
    endtask

    // Mostly valid colors, a quarter of them anywhere in the field widths.
    task automatic test_random_colors(int unsigned count);
        logic [HUE_W-1:0] hue;
        logic [PCT_W-1:0] sat;
        logic [PCT_W-1:0] val;
        for (int unsigned i = 0; i < count; i++) begin
            // A stretch in the middle runs without idling on either side.
            steady_mode = (i >= count / 2 && i < count / 2 + 150);
            if ($urandom_range(99) < 75) begin
                hue = HUE_W'($urandom_range(360));
                sat = PCT_W'($urandom_range(100));
                val = PCT_W'($urandom_range(100));
            end else begin
                hue = HUE_W'($urandom);
                sat = PCT_W'($urandom);
                val = PCT_W'($urandom);
            end
            send_color(hue, sat, val);
        end
        steady_mode = 1'b0;
    endtask

    // Receiver holds off for a long stretch while colors keep coming, filling the pipeline.
    task automatic test_output_backpressure();
        steady_mode = 1'b1;
        hold_requests++;
        for (int unsigned i = 0; i < 30; i++) begin
            send_color(HUE_W'($urandom_range(360)), PCT_W'($urandom_range(100)),
                       PCT_W'($urandom_range(100)));
        end
        steady_mode = 1'b0;
    endtask

    // Sender pauses until every result has come back, then resumes.
    task automatic test_drain_pause();
        wait_for_drain();
        for (int unsigned i = 0; i < 20; i++) begin
            send_color(HUE_W'($urandom), PCT_W'($urandom_range(100)),
                       PCT_W'($urandom_range(100)));
        end
    endtask

    // Stimulus and end of run.
    initial begin
        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        error_count   = 0;
        steady_mode   = 1'b0;
        hold_requests = 0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_directed_extremes();
        test_random_colors(RANDOM_COLORS / 2);
        test_output_backpressure();
        test_drain_pause();
        test_random_colors(RANDOM_COLORS / 2);

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("tb_hsv_to_rgbw_converter_top passed");
        end else begin
            $display("tb_hsv_to_rgbw_converter_top failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
